// ----- rtl/pavenc_pkg.sv -----
// types and constants shared by the printable ascii vigenere encipher unit
// no dependencies
package pavenc_pkg;

	localparam int SHIFT_W = 7;
	localparam logic [7:0] ALPHA_LOW = 8'd32;
	localparam logic [7:0] ALPHA_HIGH = 8'd127;
	localparam logic [7:0] ALPHA_SIZE = 8'd96;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_KEY   = 2'd1,
		KIND_ENC   = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_KEY = 2'd1,
		ST_FULL    = 2'd2,
		ST_NO_KEY  = 2'd3
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
	} res_word_t;

	typedef struct packed {
		logic               en;
		logic [SHIFT_W-1:0] shift;
	} key_wr_t;

	typedef struct packed {
		logic       enc;
		logic [7:0] data_byte;
		status_t    status;
	} ctl_s1_t;

endpackage

// ----- rtl/pavenc_key_mem.sv -----
// key shift store: one write port, one read port, registered read data
// depends on pavenc_pkg
module pavenc_key_mem #(
	parameter int DEPTH = 128,
	parameter int AW = 7
) (
	input  logic                          clk,
	input  pavenc_pkg::key_wr_t           wr,
	input  logic [AW-1:0]                 wr_addr,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [pavenc_pkg::SHIFT_W-1:0] rd_data
);

	logic [pavenc_pkg::SHIFT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.shift;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/pavenc_ctrl.sv -----
// key length and position tracking, command decode and first pipeline stage
// depends on pavenc_pkg; drives the key store ports
module pavenc_ctrl #(
	parameter int DEPTH = 128,
	parameter int AW = 7,
	parameter int LEN_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  acc,
	input  pavenc_pkg::cmd_word_t cmd,
	input  logic                  adv,
	output pavenc_pkg::key_wr_t   wr,
	output logic [AW-1:0]         wr_addr,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	output logic                  valid_s1,
	output pavenc_pkg::ctl_s1_t   ctl_s1
);

	logic [LEN_W-1:0] len_q;
	logic [AW-1:0]    pos_q;
	logic [LEN_W-1:0] len_d;
	logic [AW-1:0]    pos_d;
	logic [LEN_W-1:0] pos_inc;
	logic [7:0]       key_diff;
	logic             in_alpha;
	logic             full;
	pavenc_pkg::ctl_s1_t ctl_d;

	assign in_alpha = (cmd.data_byte >= pavenc_pkg::ALPHA_LOW) &&
		(cmd.data_byte <= pavenc_pkg::ALPHA_HIGH);
	assign full = (len_q == LEN_W'(DEPTH));
	assign key_diff = cmd.data_byte - (pavenc_pkg::ALPHA_LOW - 8'd1);
	assign pos_inc = LEN_W'(pos_q) + LEN_W'(1);
	assign wr_addr = len_q[AW-1:0];
	assign rd_addr = pos_q;

	always_comb begin
		len_d = len_q;
		pos_d = pos_q;
		wr.en = 1'b0;
		wr.shift = key_diff[pavenc_pkg::SHIFT_W-1:0];
		rd_en = 1'b0;
		ctl_d.enc = 1'b0;
		ctl_d.data_byte = 8'd0;
		ctl_d.status = pavenc_pkg::ST_OK;
		unique case (cmd.kind)
			pavenc_pkg::KIND_CLEAR: begin
				len_d = '0;
				pos_d = '0;
			end
			pavenc_pkg::KIND_KEY: begin
				if (!in_alpha) begin
					ctl_d.status = pavenc_pkg::ST_BAD_KEY;
				end else if (full) begin
					ctl_d.status = pavenc_pkg::ST_FULL;
				end else begin
					wr.en = acc;
					len_d = len_q + LEN_W'(1);
				end
			end
			pavenc_pkg::KIND_ENC: begin
				ctl_d.data_byte = cmd.data_byte;
				if (len_q == '0) begin
					ctl_d.status = pavenc_pkg::ST_NO_KEY;
				end else begin
					ctl_d.enc = 1'b1;
					rd_en = acc;
					pos_d = (pos_inc >= len_q) ? '0 : pos_inc[AW-1:0];
				end
			end
			pavenc_pkg::KIND_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			pos_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				len_q <= len_d;
				pos_q <= pos_d;
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1 <= ctl_d;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(DEPTH))
		else $error("key length beyond store depth");

	a_pos_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != '0) |-> (LEN_W'(pos_q) < len_q))
		else $error("key position not below key length");

	a_pos_zero_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == '0) |-> (pos_q == '0))
		else $error("key position nonzero with empty key");

	a_no_wr_rd_same: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.en && rd_en))
		else $error("key write and read in one cycle");

endmodule

// ----- rtl/printable_ascii_vigenere_encipher_unit.sv -----
// top level of the printable ascii vigenere encipher unit
// depends on pavenc_pkg, pavenc_key_mem and pavenc_ctrl
//
// channel  direction  word        handshake
// cmd      input      cmd_word_t  cmd_valid / cmd_stall
// res      output     res_word_t  res_valid / res_stall
//
// one word per cycle sustained while res_stall stays low; each command gives exactly one result word
// each command passes the key store read, then the shift add into the output register
// the key store has no reset; key length and position clear on arst_n
// cmd_stall rises only while the stage holding the key read and the output
// register are both full and res_stall is high
module printable_ascii_vigenere_encipher_unit #(
	parameter int KEY_DEPTH = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  pavenc_pkg::cmd_word_t cmd,
	output logic                  res_valid,
	input  logic                  res_stall,
	output pavenc_pkg::res_word_t res
);

	localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int LEN_W = $clog2(KEY_DEPTH + 1);

	logic acc;
	logic adv;
	logic valid_s1;
	pavenc_pkg::ctl_s1_t ctl_s1;
	pavenc_pkg::key_wr_t wr;
	logic [AW-1:0] wr_addr;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic [pavenc_pkg::SHIFT_W-1:0] shift_s1;
	logic [7:0] sum;
	logic [7:0] enc_byte;
	pavenc_pkg::res_word_t res_d;
	logic res_valid_q;
	pavenc_pkg::res_word_t res_q;

	assign cmd_stall = valid_s1 && res_valid_q && res_stall;
	assign acc = cmd_valid && !cmd_stall;
	assign adv = valid_s1 && (!res_valid_q || !res_stall);

	pavenc_ctrl #(
		.DEPTH(KEY_DEPTH),
		.AW(AW),
		.LEN_W(LEN_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.cmd(cmd),
		.adv(adv),
		.wr(wr),
		.wr_addr(wr_addr),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.valid_s1(valid_s1),
		.ctl_s1(ctl_s1)
	);

	pavenc_key_mem #(
		.DEPTH(KEY_DEPTH),
		.AW(AW)
	) u_key_mem (
		.clk(clk),
		.wr(wr),
		.wr_addr(wr_addr),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(shift_s1)
	);

	// alphabet bytes plus a shift of at most 96 stay below 256
	assign sum = ctl_s1.data_byte + {1'b0, shift_s1};

	always_comb begin
		enc_byte = ctl_s1.data_byte;
		if (ctl_s1.enc && (ctl_s1.data_byte >= pavenc_pkg::ALPHA_LOW) &&
			(ctl_s1.data_byte <= pavenc_pkg::ALPHA_HIGH)) begin
			enc_byte = (sum > pavenc_pkg::ALPHA_HIGH) ? (sum - pavenc_pkg::ALPHA_SIZE) : sum;
		end
		res_d.out_byte = enc_byte;
		res_d.status = ctl_s1.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && res_valid))
		else $error("input stalled with a free pipeline slot");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid)
		else $error("advanced word missing from output register");

	a_acc_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1)
		else $error("accepted word missing from first stage");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for printable_ascii_vigenere_encipher_unit: sends command words with random gaps
// and stalls, predicts every result word from its own key store copy and checks them in order
// depends on pavenc_pkg and the rtl of the unit
module tb_top;
	import pavenc_pkg::*;

	localparam int KEY_DEPTH = 128;
	localparam int WORD_TARGET = 1950;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_word_t cmd;
	logic res_valid;
	logic res_stall;
	res_word_t res;

	logic [SHIFT_W-1:0] key_shift_mem [KEY_DEPTH];
	int key_len = 0;
	int key_pos = 0;
	res_word_t pending_res [$];
	bit gaps_on = 1'b1;
	int rx_hold = 0;
	int words_sent = 0;
	int words_checked = 0;
	int stall_cycles = 0;
	int err_count = 0;

	printable_ascii_vigenere_encipher_unit #(
		.KEY_DEPTH(KEY_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic res_word_t encipher_predict(input kind_t k, input logic [7:0] b);
		res_word_t r;
		logic [7:0] sum;
		r.out_byte = 8'd0;
		r.status = ST_OK;
		case (k)
			KIND_CLEAR: begin
				key_len = 0;
				key_pos = 0;
			end
			KIND_KEY: begin
				if (b < ALPHA_LOW || b > ALPHA_HIGH)
					r.status = ST_BAD_KEY;
				else if (key_len >= KEY_DEPTH)
					r.status = ST_FULL;
				else begin
					key_shift_mem[key_len] = SHIFT_W'(b - (ALPHA_LOW - 8'd1));
					key_len++;
				end
			end
			KIND_ENC: begin
				if (key_len == 0) begin
					r.out_byte = b;
					r.status = ST_NO_KEY;
				end else begin
					if (b >= ALPHA_LOW && b <= ALPHA_HIGH) begin
						sum = b + {1'b0, key_shift_mem[key_pos]};
						if (sum > ALPHA_HIGH)
							sum = sum - ALPHA_SIZE;
						r.out_byte = sum;
					end else
						r.out_byte = b;
					key_pos = (key_pos + 1 >= key_len) ? 0 : key_pos + 1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_word(input kind_t k, input logic [7:0] b);
		cmd_word_t w;
		while (gaps_on && $urandom_range(99) < 34) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		w.kind = k;
		w.data_byte = b;
		cmd_valid <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		pending_res.push_back(encipher_predict(k, b));
		words_sent++;
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_res.size() != 0);
	endtask

	task automatic send_sequence();
		int pick;
		int n_key;
		int n_enc;
		pick = $urandom_range(99);
		if (pick < 15) begin
			// noise: any kind, any byte
			repeat ($urandom_range(1, 6))
				send_word(kind_t'($urandom_range(3)), 8'($urandom));
			return;
		end
		if ($urandom_range(9) != 0)
			send_word(KIND_CLEAR, 8'($urandom));
		pick = $urandom_range(99);
		n_key = pick < 70 ? $urandom_range(1, 8) :
			pick < 92 ? $urandom_range(9, 40) : $urandom_range(120, 135);
		repeat (n_key)
			send_word(KIND_KEY, $urandom_range(9) == 0 ? 8'($urandom) :
				8'($urandom_range(32, 127)));
		n_enc = $urandom_range(1, 30);
		repeat (n_enc)
			send_word(KIND_ENC, $urandom_range(4) == 0 ? 8'($urandom) :
				8'($urandom_range(32, 127)));
	endtask

	task automatic test_empty_key();
		send_word(KIND_ENC, 8'd0);
		send_word(KIND_ENC, 8'd32);
		send_word(KIND_ENC, 8'd127);
		send_word(KIND_ENC, 8'd128);
		send_word(KIND_ENC, 8'd255);
		send_word(KIND_NONE, 8'd0);
		send_word(KIND_NONE, 8'd255);
		send_word(KIND_CLEAR, 8'h5a);
	endtask

	task automatic test_key_edges();
		send_word(KIND_KEY, 8'd31);
		send_word(KIND_KEY, 8'd32);
		send_word(KIND_KEY, 8'd127);
		send_word(KIND_KEY, 8'd128);
		send_word(KIND_KEY, 8'd0);
		send_word(KIND_KEY, 8'd255);
		// shifts are 1 then 96: both wrap edges of the alphabet
		send_word(KIND_ENC, 8'd32);
		send_word(KIND_ENC, 8'd32);
		send_word(KIND_ENC, 8'd127);
		send_word(KIND_ENC, 8'd127);
		send_word(KIND_ENC, 8'd31);
		send_word(KIND_ENC, 8'd128);
		send_word(KIND_ENC, 8'd0);
		send_word(KIND_ENC, 8'd255);
		send_word(KIND_NONE, 8'h41);
		send_word(KIND_CLEAR, 8'hff);
	endtask

	task automatic test_full_store();
		send_word(KIND_CLEAR, 8'd0);
		repeat (KEY_DEPTH)
			send_word(KIND_KEY, 8'($urandom_range(32, 127)));
		send_word(KIND_KEY, 8'h50);
		send_word(KIND_KEY, 8'h80);
		send_word(KIND_KEY, 8'h1f);
		repeat (2 * KEY_DEPTH + 5)
			send_word(KIND_ENC, 8'($urandom));
		send_word(KIND_CLEAR, 8'($urandom));
	endtask

	task automatic test_back_pressure();
		send_word(KIND_CLEAR, 8'd0);
		repeat (4)
			send_word(KIND_KEY, 8'($urandom_range(32, 127)));
		drain_results();
		gaps_on = 1'b0;
		rx_hold = 250;
		repeat (40)
			send_word(KIND_ENC, 8'($urandom));
		gaps_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		repeat (20)
			send_word(KIND_ENC, 8'($urandom_range(32, 127)));
		drain_results();
		repeat (20)
			send_word(kind_t'($urandom_range(3)), 8'($urandom));
	endtask

	task automatic test_no_gaps();
		int start;
		start = words_sent;
		gaps_on = 1'b0;
		while (words_sent - start < 300)
			send_sequence();
		gaps_on = 1'b1;
	endtask

	task automatic test_random();
		while (words_sent < WORD_TARGET)
			send_sequence();
	endtask

	// result checker and receiver stall
	initial begin
		res_word_t want;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (cmd_valid && cmd_stall)
					stall_cycles++;
				if (res_valid && !res_stall) begin
					if (pending_res.size() == 0) begin
						$error("result word %h with none expected", res);
						err_count++;
					end else begin
						want = pending_res.pop_front();
						if (res.out_byte !== want.out_byte) begin
							$error("out_byte expected %0d actual %0d",
								want.out_byte, res.out_byte);
							err_count++;
						end
						if (res.status !== want.status) begin
							$error("status expected %0d actual %0d",
								want.status, res.status);
							err_count++;
						end
						words_checked++;
					end
				end
			end
			if (rx_hold > 0) begin
				res_stall <= 1'b1;
				rx_hold--;
			end else
				res_stall <= gaps_on && ($urandom_range(99) < 34);
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_key();
		test_key_edges();
		test_full_store();
		test_back_pressure();
		test_sender_pause();
		test_no_gaps();
		test_random();
		drain_results();
		repeat (10) @(posedge clk);
		$display("sent %0d command words, checked %0d result words, input stalled %0d cycles",
			words_sent, words_checked, stall_cycles);
		$display("covered empty key, key byte limits, full key store, wrap, long hold, pause");
		if (err_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
